/* design/scd1_pkg.sv */
package scd1_pkg;

    // scancode set 1 codes
    localparam logic [7:0] PREFIX_BYTE = 8'hE0;
    localparam logic [6:0] CODE_MASK   = 7'h7F;
    localparam logic [6:0] LSHIFT_CODE = 7'h2A;
    localparam logic [6:0] RSHIFT_CODE = 7'h36;
    localparam logic [6:0] UP_CODE     = 7'h48;
    localparam logic [6:0] DOWN_CODE   = 7'h50;
    localparam logic [6:0] LEFT_CODE   = 7'h4B;
    localparam logic [6:0] RIGHT_CODE  = 7'h4D;

    // arrow character codes
    localparam logic [7:0] CHAR_NONE   = 8'h00;
    localparam logic [7:0] CHAR_UP     = 8'h80;
    localparam logic [7:0] CHAR_DOWN   = 8'h81;
    localparam logic [7:0] CHAR_LEFT   = 8'h82;
    localparam logic [7:0] CHAR_RIGHT  = 8'h83;

    // decoder result and flag updates for one request
    typedef struct packed {
        logic       has_result;
        logic [7:0] event_code;
        logic       event_pressed;
        logic       char_valid;
        logic [7:0] char_code;
        logic       ext_next;
        logic       shift_next;
    } t_dec_out;

    // arrow character, or none
    function automatic logic [7:0] arrow_char(input logic [6:0] code);
        logic [7:0] ch;
        unique case (code)
            UP_CODE:    ch = CHAR_UP;
            DOWN_CODE:  ch = CHAR_DOWN;
            LEFT_CODE:  ch = CHAR_LEFT;
            RIGHT_CODE: ch = CHAR_RIGHT;
            default:    ch = CHAR_NONE;
        endcase
        return ch;
    endfunction

    // swiss-german layout, no shift
    function automatic logic [7:0] lay_plain(input logic [6:0] code);
        logic [7:0] ch;
        unique case (code)
            7'h02: ch = 8'h31; 7'h03: ch = 8'h32; 7'h04: ch = 8'h33; 7'h05: ch = 8'h34;
            7'h06: ch = 8'h35; 7'h07: ch = 8'h36; 7'h08: ch = 8'h37; 7'h09: ch = 8'h38;
            7'h0A: ch = 8'h39; 7'h0B: ch = 8'h30; 7'h0C: ch = 8'h27; 7'h0D: ch = 8'h5E;
            7'h0E: ch = 8'h08; 7'h0F: ch = 8'h09;
            7'h10: ch = 8'h71; 7'h11: ch = 8'h77; 7'h12: ch = 8'h65; 7'h13: ch = 8'h72;
            7'h14: ch = 8'h74; 7'h15: ch = 8'h7A; 7'h16: ch = 8'h75; 7'h17: ch = 8'h69;
            7'h18: ch = 8'h6F; 7'h19: ch = 8'h70; 7'h1C: ch = 8'h0A;
            7'h1E: ch = 8'h61; 7'h1F: ch = 8'h73;
            7'h20: ch = 8'h64; 7'h21: ch = 8'h66; 7'h22: ch = 8'h67; 7'h23: ch = 8'h68;
            7'h24: ch = 8'h6A; 7'h25: ch = 8'h6B; 7'h26: ch = 8'h6C;
            7'h2B: ch = 8'h24; 7'h2C: ch = 8'h79; 7'h2D: ch = 8'h78; 7'h2E: ch = 8'h63;
            7'h2F: ch = 8'h76;
            7'h30: ch = 8'h62; 7'h31: ch = 8'h6E; 7'h32: ch = 8'h6D; 7'h33: ch = 8'h2C;
            7'h34: ch = 8'h2E; 7'h35: ch = 8'h2D; 7'h37: ch = 8'h2A; 7'h39: ch = 8'h20;
            7'h56: ch = 8'h3C;
            default: ch = CHAR_NONE;
        endcase
        return ch;
    endfunction

    // swiss-german layout, shift held
    function automatic logic [7:0] lay_shift(input logic [6:0] code);
        logic [7:0] ch;
        unique case (code)
            7'h02: ch = 8'h2B; 7'h03: ch = 8'h22; 7'h04: ch = 8'h2A;
            7'h06: ch = 8'h25; 7'h07: ch = 8'h26; 7'h08: ch = 8'h2F; 7'h09: ch = 8'h28;
            7'h0A: ch = 8'h29; 7'h0B: ch = 8'h3D; 7'h0C: ch = 8'h3F; 7'h0D: ch = 8'h60;
            7'h0E: ch = 8'h08; 7'h0F: ch = 8'h09;
            7'h10: ch = 8'h51; 7'h11: ch = 8'h57; 7'h12: ch = 8'h45; 7'h13: ch = 8'h52;
            7'h14: ch = 8'h54; 7'h15: ch = 8'h5A; 7'h16: ch = 8'h55; 7'h17: ch = 8'h49;
            7'h18: ch = 8'h4F; 7'h19: ch = 8'h50; 7'h1B: ch = 8'h21; 7'h1C: ch = 8'h0A;
            7'h1E: ch = 8'h41; 7'h1F: ch = 8'h53;
            7'h20: ch = 8'h44; 7'h21: ch = 8'h46; 7'h22: ch = 8'h47; 7'h23: ch = 8'h48;
            7'h24: ch = 8'h4A; 7'h25: ch = 8'h4B; 7'h26: ch = 8'h4C;
            7'h2C: ch = 8'h59; 7'h2D: ch = 8'h58; 7'h2E: ch = 8'h43; 7'h2F: ch = 8'h56;
            7'h30: ch = 8'h42; 7'h31: ch = 8'h4E; 7'h32: ch = 8'h4D; 7'h33: ch = 8'h3B;
            7'h34: ch = 8'h3A; 7'h35: ch = 8'h5F; 7'h37: ch = 8'h2A; 7'h39: ch = 8'h20;
            7'h56: ch = 8'h3E;
            default: ch = CHAR_NONE;
        endcase
        return ch;
    endfunction

endpackage

/* design/scd1_decode.sv */
module scd1_decode (
    input  logic              i_scan_byte_7,
    input  logic [6:0]        i_code,
    input  logic              i_aux_source,
    input  logic              i_prefix,
    input  logic              i_ext,
    input  logic              i_shift,
    output scd1_pkg::t_dec_out o_dec
);
    import scd1_pkg::*;

    logic       pressed;
    logic       is_shift;
    logic [7:0] arrow;
    logic [7:0] layout;
    logic [7:0] ch;

    // key classification and lookups
    assign pressed  = ~i_scan_byte_7;
    assign is_shift = (i_code == LSHIFT_CODE) || (i_code == RSHIFT_CODE);
    assign arrow    = arrow_char(i_code & CODE_MASK);
    assign layout   = i_shift ? lay_shift(i_code) : lay_plain(i_code);

    // character selection
    always_comb begin
        ch = CHAR_NONE;
        if (i_ext) begin
            if (pressed) ch = arrow;
        end else if (!is_shift && pressed) begin
            ch = (arrow != CHAR_NONE) ? arrow : layout;
        end
    end

    // result and flag updates
    always_comb begin
        o_dec.has_result    = 1'b0;
        o_dec.event_code    = {i_ext, i_code};
        o_dec.event_pressed = pressed;
        o_dec.char_valid    = (ch != CHAR_NONE);
        o_dec.char_code     = ch;
        o_dec.ext_next      = i_ext;
        o_dec.shift_next    = i_shift;
        if (!i_aux_source) begin
            if (i_prefix) begin
                o_dec.ext_next = 1'b1;
            end else begin
                o_dec.has_result = 1'b1;
                o_dec.ext_next   = 1'b0;
                if (!i_ext && is_shift) o_dec.shift_next = pressed;
            end
        end
    end

endmodule

/* design/scancode_set1_key_decoder.sv */
// channel | handshake                  | payload
// --------+----------------------------+------------------------------------------
// in      | i_in_valid / o_in_stall    | i_scan_byte[7:0], i_aux_source
// out     | o_out_valid / i_out_stall  | o_event_code[7:0], o_event_pressed,
//         |                            | o_char_valid, o_char_code[7:0]
//
// one request per cycle while the input is not stalled; a request passes from the input register
// through decode and layout rom into the result register.
// aux and prefix bytes leave the input register without taking a result slot.
// reset clears both valid flags, the prefix flag and the shift flag.
// a stalled result holds in the result register; the input register stalls only
// when it holds a result-producing request that cannot move on.
module scancode_set1_key_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_scan_byte,
    input  logic       i_aux_source,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_event_code,
    output logic       o_event_pressed,
    output logic       o_char_valid,
    output logic [7:0] o_char_code
);
    import scd1_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_aux;
    logic       r_ext;
    logic       r_shift;
    logic       r_out_valid;
    logic [7:0] r_event_code;
    logic       r_event_pressed;
    logic       r_char_valid;
    logic [7:0] r_char_code;

    t_dec_out   dec;
    logic       out_free;
    logic       consume;
    logic       in_take;
    logic       n_out_valid;

    // decode of the held request
    scd1_decode u_decode (
        .i_scan_byte_7 (r_in_byte[7]),
        .i_code        (r_in_byte[6:0]),
        .i_aux_source  (r_in_aux),
        .i_prefix      (r_in_byte == PREFIX_BYTE),
        .i_ext         (r_ext),
        .i_shift       (r_shift),
        .o_dec         (dec)
    );

    // flow control
    assign out_free    = !r_out_valid || !i_out_stall;
    assign consume     = r_in_valid && (!dec.has_result || out_free);
    assign o_in_stall  = r_in_valid && !consume;
    assign in_take     = i_in_valid && !o_in_stall;
    assign n_out_valid = consume && dec.has_result;

    // input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (consume) begin
            r_in_valid <= 1'b0;
        end
    end

    // input register payload
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_scan_byte;
            r_in_aux  <= i_aux_source;
        end
    end

    // prefix and shift flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ext   <= 1'b0;
            r_shift <= 1'b0;
        end else if (consume) begin
            r_ext   <= dec.ext_next;
            r_shift <= dec.shift_next;
        end
    end

    // result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= n_out_valid;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (n_out_valid) begin
            r_event_code    <= dec.event_code;
            r_event_pressed <= dec.event_pressed;
            r_char_valid    <= dec.char_valid;
            r_char_code     <= dec.char_code;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_event_code    = r_event_code;
    assign o_event_pressed = r_event_pressed;
    assign o_char_valid    = r_char_valid;
    assign o_char_code     = r_char_code;

endmodule
